>>> hdl/abds_pkg.sv
package abds_pkg;

  // Field widths fixed by the stream format
  localparam int POS_W      = 20;
  localparam int RANGE_W    = 16;
  localparam int LABEL_W    = 16;
  localparam int PIX_W      = 13;
  localparam int SIZE_W     = 12;
  localparam int LIMIT_W    = 16;
  localparam int CORNERS    = 4;
  localparam int IN_DATA_W  = 168;
  localparam int OUT_DATA_W = 64;
  localparam int OUT_USER_W = 2;
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  // Defaults for the top level parameters
  localparam int FRACTION_BITS_DEF = 8;
  localparam int LABEL_BITS_DEF    = 16;

  // Slots of the pairwise label-equality vector
  localparam int EQ_01 = 0;
  localparam int EQ_02 = 1;
  localparam int EQ_03 = 2;
  localparam int EQ_12 = 3;
  localparam int EQ_13 = 4;
  localparam int EQ_23 = 5;
  localparam int EQ_W  = 6;

  typedef enum logic [1:0] {
    MODE_NEAREST  = 2'd0,
    MODE_BILINEAR = 2'd1,
    MODE_ADAPTIVE = 2'd2
  } mode_e;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_LIMIT  = 2'd3
  } reg_e;

  typedef struct packed {
    logic [1:0]         sample_mode;
    logic [SIZE_W-1:0]  image_width;
    logic [SIZE_W-1:0]  image_height;
    logic [LIMIT_W-1:0] depth_jump_limit;
  } cfg_t;

  // Geometry flags of one item
  typedef struct packed {
    logic [CORNERS-1:0] in_mask;   // corner lies inside the image
    logic               near_ok;   // rounded pixel lies inside the image
    logic [1:0]         near_k;    // corner that the rounded pixel hits
  } geo_t;

  // Candidate output positions, already wrapped to the output width
  typedef struct packed {
    logic [PIX_W-1:0] floor_col;
    logic [PIX_W-1:0] floor_row;
    logic [PIX_W-1:0] near_col;
    logic [PIX_W-1:0] near_row;
  } pix_t;

  // Signed width that holds floored / rounded coordinates and the image size
  function automatic int coord_w(input int frac_bits);
    return ((POS_W + 2 - frac_bits) > 14) ? (POS_W + 2 - frac_bits) : 14;
  endfunction

  // Label bits that take part in comparisons
  function automatic int label_w(input int label_bits);
    return (label_bits < LABEL_W) ? label_bits : LABEL_W;
  endfunction

endpackage

>>> hdl/abds_cfg.sv
module abds_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [abds_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [abds_pkg::APB_DATA_W-1:0] pwdata,
  output logic [abds_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready,
  output abds_pkg::cfg_t                  cfg_o
);

  localparam logic [abds_pkg::SIZE_W-1:0]  WIDTH_RESET  = abds_pkg::SIZE_W'(640);
  localparam logic [abds_pkg::SIZE_W-1:0]  HEIGHT_RESET = abds_pkg::SIZE_W'(480);
  localparam logic [abds_pkg::LIMIT_W-1:0] LIMIT_RESET  = abds_pkg::LIMIT_W'(100);

  abds_pkg::cfg_t cfg_q;
  abds_pkg::reg_e reg_sel;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_sel = abds_pkg::reg_e'(paddr[3:2]);
  assign wr_en   = psel & penable & pwrite;

  // Register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_mode      <= abds_pkg::MODE_ADAPTIVE;
      cfg_q.image_width      <= WIDTH_RESET;
      cfg_q.image_height     <= HEIGHT_RESET;
      cfg_q.depth_jump_limit <= LIMIT_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        abds_pkg::REG_MODE:   cfg_q.sample_mode      <= pwdata[1:0];
        abds_pkg::REG_WIDTH:  cfg_q.image_width      <= pwdata[abds_pkg::SIZE_W-1:0];
        abds_pkg::REG_HEIGHT: cfg_q.image_height     <= pwdata[abds_pkg::SIZE_W-1:0];
        abds_pkg::REG_LIMIT:  cfg_q.depth_jump_limit <= pwdata[abds_pkg::LIMIT_W-1:0];
        default:              cfg_q                  <= cfg_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      abds_pkg::REG_MODE:   prdata = abds_pkg::APB_DATA_W'(cfg_q.sample_mode);
      abds_pkg::REG_WIDTH:  prdata = abds_pkg::APB_DATA_W'(cfg_q.image_width);
      abds_pkg::REG_HEIGHT: prdata = abds_pkg::APB_DATA_W'(cfg_q.image_height);
      abds_pkg::REG_LIMIT:  prdata = abds_pkg::APB_DATA_W'(cfg_q.depth_jump_limit);
      default:              prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/abds_front.sv
module abds_front #(
  parameter int FRACTION_BITS = abds_pkg::FRACTION_BITS_DEF,
  parameter int LABEL_BITS    = abds_pkg::LABEL_BITS_DEF
) (
  input  logic                                              clk_i,
  input  logic [1:0]                                        en_i,
  input  abds_pkg::cfg_t                                    cfg_i,
  input  logic signed [abds_pkg::POS_W-1:0]                 u_pos_i,
  input  logic signed [abds_pkg::POS_W-1:0]                 v_pos_i,
  input  logic [abds_pkg::CORNERS-1:0][abds_pkg::RANGE_W-1:0] range_i,
  input  logic [abds_pkg::CORNERS-1:0][abds_pkg::LABEL_W-1:0] label_i,
  output logic [abds_pkg::CORNERS-1:0][2*FRACTION_BITS:0]   weight_o,
  output logic [abds_pkg::RANGE_W-1:0]                      lo_o,
  output logic [abds_pkg::RANGE_W-1:0]                      hi_o,
  output logic                                              any_o,
  output logic [abds_pkg::EQ_W-1:0]                         eq_o,
  output abds_pkg::geo_t                                    geo_o,
  output abds_pkg::pix_t                                    pix_o,
  output logic [abds_pkg::RANGE_W-1:0]                      near_range_o,
  output logic [abds_pkg::label_w(LABEL_BITS)-1:0]          near_label_o,
  output logic [abds_pkg::CORNERS-1:0][abds_pkg::label_w(LABEL_BITS)-1:0] label_o
);

  localparam int CW = abds_pkg::coord_w(FRACTION_BITS);
  localparam int LW = abds_pkg::label_w(LABEL_BITS);
  localparam int WW = 2 * FRACTION_BITS + 1;
  localparam int XW = abds_pkg::POS_W + 1;
  localparam int RW = abds_pkg::RANGE_W;
  localparam logic signed [XW-1:0] HALF = XW'(2 ** (FRACTION_BITS - 1));
  localparam logic [WW-1:0]        ONE  = WW'(2 ** FRACTION_BITS);

  // Round half away from zero
  function automatic logic signed [CW-1:0] round_pos(
    input logic signed [abds_pkg::POS_W-1:0] p
  );
    logic signed [XW-1:0] px;
    logic signed [XW-1:0] mag;
    logic signed [XW-1:0] quo;
    px  = XW'(p);
    mag = p[abds_pkg::POS_W-1] ? -px : px;
    quo = (mag + HALF) >>> FRACTION_BITS;
    return p[abds_pkg::POS_W-1] ? -CW'(quo) : CW'(quo);
  endfunction

  // ---------------- stage 1: coordinates and bounds ----------------
  logic signed [CW-1:0] fc, fr, fc1, fr1, rc, rr, wd, ht;
  logic                 col0, col1, row0, row1;
  abds_pkg::geo_t       geo1_d, geo1_q;
  abds_pkg::pix_t       pix1_d, pix1_q;
  logic [FRACTION_BITS-1:0] du1_q, dv1_q;
  logic [abds_pkg::CORNERS-1:0][RW-1:0] rng1_q;
  logic [abds_pkg::CORNERS-1:0][LW-1:0] lab1_q;

  always_comb begin
    fc  = CW'(u_pos_i >>> FRACTION_BITS);
    fr  = CW'(v_pos_i >>> FRACTION_BITS);
    fc1 = fc + CW'(1);
    fr1 = fr + CW'(1);
    rc  = round_pos(u_pos_i);
    rr  = round_pos(v_pos_i);
    wd  = CW'({1'b0, cfg_i.image_width});
    ht  = CW'({1'b0, cfg_i.image_height});

    col0 = !fc[CW-1]  && (fc  < wd);
    col1 = !fc1[CW-1] && (fc1 < wd);
    row0 = !fr[CW-1]  && (fr  < ht);
    row1 = !fr1[CW-1] && (fr1 < ht);

    // corner order: top-left, bottom-left, top-right, bottom-right
    geo1_d.in_mask = {col1 & row1, col1 & row0, col0 & row1, col0 & row0};
    geo1_d.near_ok = !rc[CW-1] && !rr[CW-1] && (rc < wd) && (rr < ht);
    geo1_d.near_k  = {rc[0] ^ fc[0], rr[0] ^ fr[0]};

    pix1_d.floor_col = fc[abds_pkg::PIX_W-1:0];
    pix1_d.floor_row = fr[abds_pkg::PIX_W-1:0];
    pix1_d.near_col  = rc[abds_pkg::PIX_W-1:0];
    pix1_d.near_row  = rr[abds_pkg::PIX_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      geo1_q <= geo1_d;
      pix1_q <= pix1_d;
      du1_q  <= u_pos_i[FRACTION_BITS-1:0];
      dv1_q  <= v_pos_i[FRACTION_BITS-1:0];
      rng1_q <= range_i;
      for (int c = 0; c < abds_pkg::CORNERS; c++) begin
        lab1_q[c] <= label_i[c][LW-1:0];
      end
    end
  end

  // ---------------- stage 2: weights, spread, label match ----------------
  logic [WW-1:0] du_x, dv_x, sdu, sdv;
  logic [abds_pkg::CORNERS-1:0][WW-1:0] w2_d, w2_q;
  logic [abds_pkg::CORNERS-1:0][RW-1:0] rmin, rmax;
  logic [RW-1:0] min01, min23, max01, max23, lo2_d, hi2_d, lo2_q, hi2_q;
  logic [abds_pkg::EQ_W-1:0] eq2_d, eq2_q;
  logic any2_q;
  abds_pkg::geo_t geo2_q;
  abds_pkg::pix_t pix2_q;
  logic [RW-1:0] nrng2_q;
  logic [LW-1:0] nlab2_q;
  logic [abds_pkg::CORNERS-1:0][LW-1:0] lab2_q;

  always_comb begin
    du_x = WW'(du1_q);
    dv_x = WW'(dv1_q);
    sdu  = ONE - du_x;
    sdv  = ONE - dv_x;
    w2_d[0] = sdu * sdv;
    w2_d[1] = sdu * dv_x;
    w2_d[2] = du_x * sdv;
    w2_d[3] = du_x * dv_x;

    // corners outside the image drop out of the min / max
    for (int c = 0; c < abds_pkg::CORNERS; c++) begin
      rmin[c] = geo1_q.in_mask[c] ? rng1_q[c] : '1;
      rmax[c] = geo1_q.in_mask[c] ? rng1_q[c] : '0;
    end
    min01 = (rmin[1] < rmin[0]) ? rmin[1] : rmin[0];
    min23 = (rmin[3] < rmin[2]) ? rmin[3] : rmin[2];
    max01 = (rmax[1] > rmax[0]) ? rmax[1] : rmax[0];
    max23 = (rmax[3] > rmax[2]) ? rmax[3] : rmax[2];
    lo2_d = (min23 < min01) ? min23 : min01;
    hi2_d = (max23 > max01) ? max23 : max01;

    eq2_d[abds_pkg::EQ_01] = (lab1_q[0] == lab1_q[1]);
    eq2_d[abds_pkg::EQ_02] = (lab1_q[0] == lab1_q[2]);
    eq2_d[abds_pkg::EQ_03] = (lab1_q[0] == lab1_q[3]);
    eq2_d[abds_pkg::EQ_12] = (lab1_q[1] == lab1_q[2]);
    eq2_d[abds_pkg::EQ_13] = (lab1_q[1] == lab1_q[3]);
    eq2_d[abds_pkg::EQ_23] = (lab1_q[2] == lab1_q[3]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      w2_q    <= w2_d;
      lo2_q   <= lo2_d;
      hi2_q   <= hi2_d;
      any2_q  <= |geo1_q.in_mask;
      eq2_q   <= eq2_d;
      geo2_q  <= geo1_q;
      pix2_q  <= pix1_q;
      nrng2_q <= rng1_q[geo1_q.near_k];
      nlab2_q <= lab1_q[geo1_q.near_k];
      lab2_q  <= lab1_q;
    end
  end

  assign weight_o     = w2_q;
  assign lo_o         = lo2_q;
  assign hi_o         = hi2_q;
  assign any_o        = any2_q;
  assign eq_o         = eq2_q;
  assign geo_o        = geo2_q;
  assign pix_o        = pix2_q;
  assign near_range_o = nrng2_q;
  assign near_label_o = nlab2_q;
  assign label_o      = lab2_q;

endmodule

>>> hdl/abds_back.sv
module abds_back #(
  parameter int FRACTION_BITS = abds_pkg::FRACTION_BITS_DEF,
  parameter int LABEL_BITS    = abds_pkg::LABEL_BITS_DEF
) (
  input  logic                                            clk_i,
  input  logic [2:0]                                      en_i,
  input  abds_pkg::cfg_t                                  cfg_i,
  input  logic [abds_pkg::CORNERS-1:0][2*FRACTION_BITS:0] weight_i,
  input  logic [abds_pkg::RANGE_W-1:0]                    lo_i,
  input  logic [abds_pkg::RANGE_W-1:0]                    hi_i,
  input  logic                                            any_i,
  input  logic [abds_pkg::EQ_W-1:0]                       eq_i,
  input  abds_pkg::geo_t                                  geo_i,
  input  abds_pkg::pix_t                                  pix_i,
  input  logic [abds_pkg::CORNERS-1:0][abds_pkg::RANGE_W-1:0] range_i,
  input  logic [abds_pkg::RANGE_W-1:0]                    near_range_i,
  input  logic [abds_pkg::label_w(LABEL_BITS)-1:0]        near_label_i,
  input  logic [abds_pkg::CORNERS-1:0][abds_pkg::label_w(LABEL_BITS)-1:0] label_i,
  output logic                                            sample_valid_o,
  output logic                                            blended_o,
  output logic [abds_pkg::PIX_W-1:0]                      pixel_col_o,
  output logic [abds_pkg::PIX_W-1:0]                      pixel_row_o,
  output logic [abds_pkg::RANGE_W-1:0]                    range_out_o,
  output logic [abds_pkg::LABEL_W-1:0]                    label_out_o
);

  localparam int LW = abds_pkg::label_w(LABEL_BITS);
  localparam int WW = 2 * FRACTION_BITS + 1;
  localparam int RW = abds_pkg::RANGE_W;
  localparam int PW = RW + WW;
  localparam int AW = PW + 2;
  localparam int NC = abds_pkg::CORNERS;

  // ---------------- stage 3: mode decision, products, pooled weights ----------------
  logic spread_far, near3_d;
  logic [NC-1:0][PW-1:0] prod3_d, prod3_q;
  logic [NC-1:0][WW-1:0] pool3_d, pool3_q;
  logic near3_q;
  abds_pkg::geo_t geo3_q;
  abds_pkg::pix_t pix3_q;
  logic [RW-1:0] nrng3_q;
  logic [LW-1:0] nlab3_q;
  logic [NC-1:0][LW-1:0] lab3_q;

  always_comb begin
    spread_far = any_i && ((hi_i - lo_i) > cfg_i.depth_jump_limit);
    near3_d    = (cfg_i.sample_mode == abds_pkg::MODE_NEAREST) ||
                 ((cfg_i.sample_mode != abds_pkg::MODE_BILINEAR) && spread_far);

    for (int c = 0; c < NC; c++) begin
      prod3_d[c] = PW'(range_i[c]) * PW'(weight_i[c]);
    end

    // each corner gets the total weight of all corners sharing its label
    pool3_d[0] = weight_i[0]
               + (eq_i[abds_pkg::EQ_01] ? weight_i[1] : '0)
               + (eq_i[abds_pkg::EQ_02] ? weight_i[2] : '0)
               + (eq_i[abds_pkg::EQ_03] ? weight_i[3] : '0);
    pool3_d[1] = weight_i[1]
               + (eq_i[abds_pkg::EQ_01] ? weight_i[0] : '0)
               + (eq_i[abds_pkg::EQ_12] ? weight_i[2] : '0)
               + (eq_i[abds_pkg::EQ_13] ? weight_i[3] : '0);
    pool3_d[2] = weight_i[2]
               + (eq_i[abds_pkg::EQ_02] ? weight_i[0] : '0)
               + (eq_i[abds_pkg::EQ_12] ? weight_i[1] : '0)
               + (eq_i[abds_pkg::EQ_23] ? weight_i[3] : '0);
    pool3_d[3] = weight_i[3]
               + (eq_i[abds_pkg::EQ_03] ? weight_i[0] : '0)
               + (eq_i[abds_pkg::EQ_13] ? weight_i[1] : '0)
               + (eq_i[abds_pkg::EQ_23] ? weight_i[2] : '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      prod3_q <= prod3_d;
      pool3_q <= pool3_d;
      near3_q <= near3_d;
      geo3_q  <= geo_i;
      pix3_q  <= pix_i;
      nrng3_q <= near_range_i;
      nlab3_q <= near_label_i;
      lab3_q  <= label_i;
    end
  end

  // ---------------- stage 4: range sum, first round of the vote ----------------
  logic [AW-1:0] acc;
  logic [RW-1:0] brng4_q;
  logic [1:0]    idx01_d, idx23_d, idx01_q, idx23_q;
  logic [WW-1:0] val01_d, val23_d, val01_q, val23_q;
  logic near4_q;
  abds_pkg::geo_t geo4_q;
  abds_pkg::pix_t pix4_q;
  logic [RW-1:0] nrng4_q;
  logic [LW-1:0] nlab4_q;
  logic [NC-1:0][LW-1:0] lab4_q;

  always_comb begin
    acc = AW'(prod3_q[0]) + AW'(prod3_q[1]) + AW'(prod3_q[2]) + AW'(prod3_q[3]);
    // ties keep the lower corner
    idx01_d = (pool3_q[1] > pool3_q[0]) ? 2'd1 : 2'd0;
    val01_d = (pool3_q[1] > pool3_q[0]) ? pool3_q[1] : pool3_q[0];
    idx23_d = (pool3_q[3] > pool3_q[2]) ? 2'd3 : 2'd2;
    val23_d = (pool3_q[3] > pool3_q[2]) ? pool3_q[3] : pool3_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      brng4_q <= acc[2*FRACTION_BITS +: RW];
      idx01_q <= idx01_d;
      val01_q <= val01_d;
      idx23_q <= idx23_d;
      val23_q <= val23_d;
      near4_q <= near3_q;
      geo4_q  <= geo3_q;
      pix4_q  <= pix3_q;
      nrng4_q <= nrng3_q;
      nlab4_q <= nlab3_q;
      lab4_q  <= lab3_q;
    end
  end

  // ---------------- stage 5: final vote and result select ----------------
  logic [1:0] win;
  logic       patch_ok;
  logic       valid_d, blend_d, valid_q, blend_q;
  logic [abds_pkg::PIX_W-1:0] col_d, row_d, col_q, row_q;
  logic [RW-1:0] rng_d, rng_q;
  logic [LW-1:0] lab_d;
  logic [abds_pkg::LABEL_W-1:0] lab_q;

  always_comb begin
    win      = (val23_q > val01_q) ? idx23_q : idx01_q;
    patch_ok = &geo4_q.in_mask;
    if (near4_q) begin
      valid_d = geo4_q.near_ok;
      blend_d = 1'b0;
      col_d   = pix4_q.near_col;
      row_d   = pix4_q.near_row;
      rng_d   = geo4_q.near_ok ? nrng4_q : '0;
      lab_d   = geo4_q.near_ok ? nlab4_q : '0;
    end else begin
      valid_d = patch_ok;
      blend_d = patch_ok;
      col_d   = pix4_q.floor_col;
      row_d   = pix4_q.floor_row;
      rng_d   = patch_ok ? brng4_q : '0;
      lab_d   = patch_ok ? lab4_q[win] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      valid_q <= valid_d;
      blend_q <= blend_d;
      col_q   <= col_d;
      row_q   <= row_d;
      rng_q   <= rng_d;
      lab_q   <= abds_pkg::LABEL_W'(lab_d);
    end
  end

  assign sample_valid_o = valid_q;
  assign blended_o      = blend_q;
  assign pixel_col_o    = col_q;
  assign pixel_row_o    = row_q;
  assign range_out_o    = rng_q;
  assign label_out_o    = lab_q;

endmodule

>>> hdl/adaptive_bilinear_depth_sampler_core.sv
// Depth sampler for projected points: each request carries a fixed point image
// position and the range and label of the 2x2 pixel patch at its floor; the
// block returns one result per request, picked by sample_mode as the nearest
// pixel (rounded half away from zero), a bilinear blend of the patch with a
// weight-voted label, or adaptively the blend unless the in-image corner ranges
// spread by more than depth_jump_limit. Requests are independent and flow
// through five register stages (coordinate decode, weights and range spread,
// products and label pooling, range sum and pair vote, result register), so
// the block takes one request per clock while the result stream is not held
// back; a held result stalls only the stages behind it, and bubbles close
// up. Registers sit on the APB port at byte addresses 0 (mode), 4 (width),
// 8 (height) and 12 (jump limit) and are meant to be written while no
// request is in flight. There is no start-up sweep.
module adaptive_bilinear_depth_sampler_core #(
  parameter int FRACTION_BITS = abds_pkg::FRACTION_BITS_DEF,
  parameter int LABEL_BITS    = abds_pkg::LABEL_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // request stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // u_pos[19:0], v_pos[39:20], range_top_left[55:40], range_bottom_left[71:56],
  // range_top_right[87:72], range_bottom_right[103:88], label_top_left[119:104],
  // label_bottom_left[135:120], label_top_right[151:136],
  // label_bottom_right[167:152]
  input  logic [abds_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // pixel_col[12:0], pixel_row[25:13], range_out[41:26], label_out[57:42],
  // zero fill[63:58]
  output logic [abds_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // sample_valid[0], blended[1]
  output logic [abds_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [abds_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [abds_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [abds_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int STAGES = 5;
  localparam int LW     = abds_pkg::label_w(LABEL_BITS);
  localparam int WW     = 2 * FRACTION_BITS + 1;
  localparam int NC     = abds_pkg::CORNERS;
  localparam int RW     = abds_pkg::RANGE_W;
  localparam int RNG_LSB = 2 * abds_pkg::POS_W;
  localparam int LAB_LSB = RNG_LSB + NC * RW;

  abds_pkg::cfg_t cfg;

  // Valid chain: a stage loads when it is empty or its successor moves
  logic [STAGES-1:0] vld_d, vld_q, en;

  always_comb begin
    en[STAGES-1] = ~vld_q[STAGES-1] | m_axis_tready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[STAGES-1];

  // Request unpacking
  logic signed [abds_pkg::POS_W-1:0] u_pos, v_pos;
  logic [NC-1:0][RW-1:0]                 range_in;
  logic [NC-1:0][abds_pkg::LABEL_W-1:0]  label_in;

  always_comb begin
    u_pos = s_axis_tdata[0 +: abds_pkg::POS_W];
    v_pos = s_axis_tdata[abds_pkg::POS_W +: abds_pkg::POS_W];
    for (int c = 0; c < NC; c++) begin
      range_in[c] = s_axis_tdata[RNG_LSB + c * RW +: RW];
      label_in[c] = s_axis_tdata[LAB_LSB + c * abds_pkg::LABEL_W +: abds_pkg::LABEL_W];
    end
  end

  abds_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Front half to back half
  logic [NC-1:0][WW-1:0] weight;
  logic [RW-1:0]         lo, hi;
  logic                  any_in;
  logic [abds_pkg::EQ_W-1:0] eq;
  abds_pkg::geo_t        geo;
  abds_pkg::pix_t        pix;
  logic [RW-1:0]         near_range;
  logic [LW-1:0]         near_label;
  logic [NC-1:0][LW-1:0] label_mid;
  logic [NC-1:0][RW-1:0] range_mid;

  abds_front #(
    .FRACTION_BITS (FRACTION_BITS),
    .LABEL_BITS    (LABEL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .en_i         (en[1:0]),
    .cfg_i        (cfg),
    .u_pos_i      (u_pos),
    .v_pos_i      (v_pos),
    .range_i      (range_in),
    .label_i      (label_in),
    .weight_o     (weight),
    .lo_o         (lo),
    .hi_o         (hi),
    .any_o        (any_in),
    .eq_o         (eq),
    .geo_o        (geo),
    .pix_o        (pix),
    .near_range_o (near_range),
    .near_label_o (near_label),
    .label_o      (label_mid)
  );

  // products are taken in stage 3 from the weights; the ranges themselves
  // are only needed there, so they come from the request input through the
  // weight-aligned copy below (rng_s1_q, rng_s2_q)
  logic [NC-1:0][RW-1:0] rng_s2_q;
  logic [NC-1:0][RW-1:0] rng_s1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rng_s1_q <= range_in;
    end
    if (en[1]) begin
      rng_s2_q <= rng_s1_q;
    end
  end

  assign range_mid = rng_s2_q;

  logic                         sample_valid, blended;
  logic [abds_pkg::PIX_W-1:0]   pixel_col, pixel_row;
  logic [RW-1:0]                range_out;
  logic [abds_pkg::LABEL_W-1:0] label_out;

  abds_back #(
    .FRACTION_BITS (FRACTION_BITS),
    .LABEL_BITS    (LABEL_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .en_i           (en[4:2]),
    .cfg_i          (cfg),
    .weight_i       (weight),
    .lo_i           (lo),
    .hi_i           (hi),
    .any_i          (any_in),
    .eq_i           (eq),
    .geo_i          (geo),
    .pix_i          (pix),
    .range_i        (range_mid),
    .near_range_i   (near_range),
    .near_label_i   (near_label),
    .label_i        (label_mid),
    .sample_valid_o (sample_valid),
    .blended_o      (blended),
    .pixel_col_o    (pixel_col),
    .pixel_row_o    (pixel_row),
    .range_out_o    (range_out),
    .label_out_o    (label_out)
  );

  // Result packing
  assign m_axis_tdata = abds_pkg::OUT_DATA_W'({label_out, range_out, pixel_row, pixel_col});
  assign m_axis_tuser = {blended, sample_valid};

endmodule
